/* hdl/aes_pkg.sv */
// Package: payload types, S-box, round constants and round helpers for the AES encrypt block.
package aes_pkg;

    localparam int NumRounds = 14;
    localparam int NumKeyWords = 60;

    typedef struct packed {
        logic [63:0] plain_high;
        logic [63:0] plain_low;
    } t_in_item;

    typedef struct packed {
        logic [63:0] cipher_high;
        logic [63:0] cipher_low;
    } t_out_item;

    typedef enum logic [2:0] {
        REG_KEY_LENGTH = 3'd0,
        REG_KEY_WORD_0 = 3'd1,
        REG_KEY_WORD_1 = 3'd2,
        REG_KEY_WORD_2 = 3'd3,
        REG_KEY_WORD_3 = 3'd4
    } t_reg_index;

    typedef enum logic [1:0] {
        KEY_128 = 2'd0,
        KEY_192 = 2'd1,
        KEY_256 = 2'd2,
        KEY_SAT = 2'd3
    } t_key_len;

    localparam logic [7:0] SBOX [256] = '{
        8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
        8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
        8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
        8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
        8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
        8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
        8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
        8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
        8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
        8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
        8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
        8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
        8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
        8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
        8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
        8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
    };

    localparam logic [7:0] RCON [10] = '{
        8'h01,8'h02,8'h04,8'h08,8'h10,8'h20,8'h40,8'h80,8'h1b,8'h36
    };

    function automatic logic [7:0] xtime(input logic [7:0] v);
        return {v[6:0], 1'b0} ^ (v[7] ? 8'h1b : 8'h00);
    endfunction

    function automatic logic [31:0] sub_word(input logic [31:0] w);
        return {SBOX[w[31:24]], SBOX[w[23:16]], SBOX[w[15:8]], SBOX[w[7:0]]};
    endfunction

    // byte k of the block sits at bits 127-8k .. 120-8k
    function automatic logic [127:0] sub_shift(input logic [127:0] s);
        logic [127:0] t;
        t = '0;
        for (int c = 0; c < 4; c++) begin
            for (int r = 0; r < 4; r++) begin
                t[127 - 8*(4*c + r) -: 8] = SBOX[s[127 - 8*(4*((c + r) % 4) + r) -: 8]];
            end
        end
        return t;
    endfunction

    function automatic logic [127:0] mix_cols(input logic [127:0] s);
        logic [127:0] t;
        logic [7:0] a0, a1, a2, a3, al;
        t = '0;
        for (int c = 0; c < 4; c++) begin
            a0 = s[127 - 32*c -: 8];
            a1 = s[119 - 32*c -: 8];
            a2 = s[111 - 32*c -: 8];
            a3 = s[103 - 32*c -: 8];
            al = a0 ^ a1 ^ a2 ^ a3;
            t[127 - 32*c -: 8] = a0 ^ al ^ xtime(a0 ^ a1);
            t[119 - 32*c -: 8] = a1 ^ al ^ xtime(a1 ^ a2);
            t[111 - 32*c -: 8] = a2 ^ al ^ xtime(a2 ^ a3);
            t[103 - 32*c -: 8] = a3 ^ al ^ xtime(a3 ^ a0);
        end
        return t;
    endfunction

endpackage

/* hdl/aes_key_sched.sv */
// Key schedule: iterative expansion of the configured key into registered round keys.
module aes_key_sched import aes_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_load,
    input  logic [1:0]            i_key_length,
    input  logic [255:0]          i_key,
    output logic                  o_ready,
    output logic [3:0]            o_num_rounds,
    output logic [NumRounds:0][127:0] o_round_keys
);

    logic [NumKeyWords-1:0][31:0] r_w;
    logic [NumKeyWords-1:0][31:0] n_w;
    logic [5:0]                   r_idx;
    logic [5:0]                   n_idx;
    logic                         r_busy;
    logic                         n_busy;
    logic [3:0]                   r_nk;
    logic [3:0]                   n_nk;
    logic [3:0]                   r_ik;
    logic [3:0]                   n_ik;
    logic [3:0]                   r_rc;
    logic [3:0]                   n_rc;
    logic [31:0]                  w_t;
    logic [31:0]                  w_prev;
    logic [31:0]                  w_back;
    logic [255:0]                 w_key_al;

    // shift in one schedule word per cycle, restarted on every key register write
    always_comb begin
        n_w      = r_w;
        n_idx    = r_idx;
        n_busy   = r_busy;
        n_nk     = r_nk;
        n_ik     = r_ik;
        n_rc     = r_rc;
        w_key_al = i_key;
        w_prev   = r_w[NumKeyWords-1];
        case (r_nk)
            4'd4:    w_back = r_w[NumKeyWords-4];
            4'd6:    w_back = r_w[NumKeyWords-6];
            default: w_back = r_w[NumKeyWords-8];
        endcase
        w_t    = w_prev;
        if (r_ik == 4'd0) begin
            w_t = sub_word({w_prev[23:0], w_prev[31:24]}) ^ {RCON[r_rc], 24'h0};
        end else if (r_nk == 4'd8 && r_ik == 4'd4) begin
            w_t = sub_word(w_prev);
        end
        if (i_load) begin
            n_nk = (i_key_length == KEY_128) ? 4'd4 : (i_key_length == KEY_192) ? 4'd6 : 4'd8;
            case (n_nk)
                4'd4:    w_key_al = {128'd0, i_key[255:128]};
                4'd6:    w_key_al = {64'd0, i_key[255:64]};
                default: w_key_al = i_key;
            endcase
            for (int i = 0; i < 8; i++) begin
                n_w[NumKeyWords-8+i] = w_key_al[255 - 32*i -: 32];
            end
            n_idx  = {2'b00, n_nk};
            n_ik   = 4'd0;
            n_rc   = 4'd0;
            n_busy = 1'b1;
        end else if (r_busy) begin
            for (int i = 0; i < NumKeyWords-1; i++) begin
                n_w[i] = r_w[i+1];
            end
            n_w[NumKeyWords-1] = w_back ^ w_t;
            n_idx = r_idx + 6'd1;
            if (r_ik == r_nk - 4'd1) begin
                n_ik = 4'd0;
                n_rc = (r_rc == 4'd9) ? 4'd0 : r_rc + 4'd1;
            end else begin
                n_ik = r_ik + 4'd1;
            end
            if (r_idx == 6'(NumKeyWords - 1)) begin
                n_busy = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx  <= 6'd4;
            r_busy <= 1'b1;
            r_nk   <= 4'd4;
            r_ik   <= 4'd0;
            r_rc   <= 4'd0;
            r_w    <= '0;
        end else begin
            r_idx  <= n_idx;
            r_busy <= n_busy;
            r_nk   <= n_nk;
            r_ik   <= n_ik;
            r_rc   <= n_rc;
            r_w    <= n_w;
        end
    end

    always_comb begin
        for (int k = 0; k <= NumRounds; k++) begin
            o_round_keys[k] = {r_w[4*k], r_w[4*k+1], r_w[4*k+2], r_w[4*k+3]};
        end
    end

    assign o_ready      = !r_busy;
    assign o_num_rounds = r_nk + 4'd6;

endmodule

/* hdl/aes_block_encrypt.sv */
// Top level: AES-128/192/256 block encryption, one round per pipeline stage.
//
//  channel   direction  handshake            payload
//  command   in         i_start / o_busy     i_item (plain_high, plain_low)
//  result    out        o_done strobe        o_item (cipher_high, cipher_low)
//  config    in         APB psel/penable     key_length, key_word_0..3
//
// One item per cycle while busy is low; every key length uses the same pipeline depth
// (shorter keys pass the last rounds through unchanged). After reset or any key write
// the schedule computes the remaining words of its 60-word table, one word per cycle,
// with busy high. Reset clears the valid bits, the key registers and the schedule
// state, but not the state pipeline. Results cannot be stalled.
module aes_block_encrypt import aes_pkg::*; (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_start,
    output logic         o_busy,
    input  t_in_item     i_item,
    output logic         o_done,
    output t_out_item    o_item,
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [5:0]   paddr,
    input  logic [63:0]  pwdata,
    output logic [63:0]  prdata,
    output logic         pready
);

    logic [1:0]                   r_key_length;
    logic [1:0]                   n_key_length;
    logic [3:0][63:0]             r_key_word;
    logic [3:0][63:0]             n_key_word;
    logic                         w_wr;
    logic [2:0]                   w_reg;
    logic                         w_sched_ready;
    logic [3:0]                   w_num_rounds;
    logic [NumRounds:0][127:0]    w_rk;
    logic [NumRounds+1:0]         r_valid;
    logic [NumRounds+1:0][127:0]  r_state;
    logic [NumRounds+1:0][127:0]  n_state;
    logic [127:0]                 w_ss;

    assign pready = 1'b1;
    assign w_wr   = psel && penable && pwrite;
    assign w_reg  = paddr[5:3];

    always_comb begin
        n_key_length = r_key_length;
        n_key_word   = r_key_word;
        if (w_wr) begin
            case (w_reg)
                REG_KEY_LENGTH: n_key_length  = pwdata[1:0];
                REG_KEY_WORD_0: n_key_word[0] = pwdata;
                REG_KEY_WORD_1: n_key_word[1] = pwdata;
                REG_KEY_WORD_2: n_key_word[2] = pwdata;
                REG_KEY_WORD_3: n_key_word[3] = pwdata;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key_length <= 2'd0;
            r_key_word   <= '0;
        end else begin
            r_key_length <= n_key_length;
            r_key_word   <= n_key_word;
        end
    end

    always_comb begin
        case (w_reg)
            REG_KEY_LENGTH: prdata = {62'd0, r_key_length};
            REG_KEY_WORD_0: prdata = r_key_word[0];
            REG_KEY_WORD_1: prdata = r_key_word[1];
            REG_KEY_WORD_2: prdata = r_key_word[2];
            REG_KEY_WORD_3: prdata = r_key_word[3];
            default:        prdata = '0;
        endcase
    end

    aes_key_sched u_sched (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_load       (w_wr && w_reg <= REG_KEY_WORD_3),
        .i_key_length (n_key_length),
        .i_key        ({n_key_word[0], n_key_word[1], n_key_word[2], n_key_word[3]}),
        .o_ready      (w_sched_ready),
        .o_num_rounds (w_num_rounds),
        .o_round_keys (w_rk)
    );

    assign o_busy = !w_sched_ready;

    // stage 0: initial key add; stage k: round k, or pass through beyond the last round
    always_comb begin
        n_state[0] = {i_item.plain_high, i_item.plain_low} ^ w_rk[0];
        w_ss = '0;
        for (int k = 1; k <= NumRounds; k++) begin
            w_ss = sub_shift(r_state[k-1]);
            if (4'(k) > w_num_rounds) begin
                n_state[k] = r_state[k-1];
            end else if (4'(k) == w_num_rounds) begin
                n_state[k] = w_ss ^ w_rk[k];
            end else begin
                n_state[k] = mix_cols(w_ss) ^ w_rk[k];
            end
        end
        n_state[NumRounds+1] = r_state[NumRounds];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else begin
            r_valid <= {r_valid[NumRounds:0], i_start && !o_busy};
        end
        r_state <= n_state;
    end

    assign o_done = r_valid[NumRounds+1];
    assign o_item = '{cipher_high: r_state[NumRounds+1][127:64],
                      cipher_low:  r_state[NumRounds+1][63:0]};

`ifndef SYNTHESIS
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_start && !o_busy) |-> ##16 o_done)
        else $error("item lost in pipeline");
    a_no_spurious: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> $past(r_valid[0], 15))
        else $error("result without item");
    a_key_write_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_wr && paddr[5:3] == REG_KEY_WORD_0) |=> o_busy)
        else $error("key write did not restart schedule");
`endif

endmodule

/* test/aes_block_encrypt_check.sv */
// Checker for the AES block encrypt testbench: predicts ciphertexts and compares results.
`timescale 1ns / 1ps

module aes_block_encrypt_check import aes_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic        i_busy,
    input  t_in_item    i_item,
    input  logic        i_done,
    input  t_out_item   i_result,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic        pready,
    input  logic [5:0]  paddr,
    input  logic [63:0] pwdata,
    output int          o_fail_count,
    output int          o_pending
);

    localparam logic [7:0] SUB_TAB [256] = '{
        8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
        8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
        8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
        8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
        8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
        8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
        8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
        8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
        8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
        8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
        8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
        8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
        8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
        8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
        8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
        8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
    };

    logic [1:0]  key_len;
    logic [63:0] key_words [4];
    t_out_item   cipher_queue [$];
    int          fail_count;

    function automatic logic [7:0] gf_double(input logic [7:0] v);
        return {v[6:0], 1'b0} ^ (v[7] ? 8'h1b : 8'h00);
    endfunction

    function automatic t_out_item encrypt_block(input t_in_item blk);
        logic [7:0]  kb [32];
        logic [31:0] sched [60];
        logic [7:0]  st [16];
        logic [7:0]  tmp [16];
        logic [7:0]  rcon;
        logic [31:0] w;
        logic [7:0]  a0, a1, a2, a3, al;
        int          nk, nr;
        t_out_item   res;
        nk = (key_len == KEY_128) ? 4 : (key_len == KEY_192) ? 6 : 8;
        nr = nk + 6;
        for (int k = 0; k < 32; k++) kb[k] = key_words[k / 8][63 - 8 * (k % 8) -: 8];
        for (int i = 0; i < nk; i++) sched[i] = {kb[4*i], kb[4*i+1], kb[4*i+2], kb[4*i+3]};
        rcon = 8'h01;
        for (int i = nk; i < 4 * (nr + 1); i++) begin
            w = sched[i-1];
            if (i % nk == 0) begin
                w = {SUB_TAB[w[23:16]] ^ rcon, SUB_TAB[w[15:8]], SUB_TAB[w[7:0]],
                     SUB_TAB[w[31:24]]};
                rcon = gf_double(rcon);
            end else if (nk > 6 && i % nk == 4) begin
                w = {SUB_TAB[w[31:24]], SUB_TAB[w[23:16]], SUB_TAB[w[15:8]], SUB_TAB[w[7:0]]};
            end
            sched[i] = sched[i-nk] ^ w;
        end
        for (int k = 0; k < 16; k++) st[k] = blk[127 - 8 * k -: 8];
        for (int rnd = 0; rnd <= nr; rnd++) begin
            if (rnd > 0) begin
                for (int c = 0; c < 4; c++)
                    for (int r = 0; r < 4; r++) tmp[4*c+r] = SUB_TAB[st[4*((c+r)%4)+r]];
                st = tmp;
                if (rnd != nr) begin
                    for (int c = 0; c < 4; c++) begin
                        a0 = st[4*c]; a1 = st[4*c+1]; a2 = st[4*c+2]; a3 = st[4*c+3];
                        al = a0 ^ a1 ^ a2 ^ a3;
                        st[4*c]   = a0 ^ al ^ gf_double(a0 ^ a1);
                        st[4*c+1] = a1 ^ al ^ gf_double(a1 ^ a2);
                        st[4*c+2] = a2 ^ al ^ gf_double(a2 ^ a3);
                        st[4*c+3] = a3 ^ al ^ gf_double(a3 ^ a0);
                    end
                end
            end
            for (int c = 0; c < 4; c++)
                for (int r = 0; r < 4; r++) st[4*c+r] ^= sched[4*rnd+c][31 - 8*r -: 8];
        end
        for (int k = 0; k < 16; k++) res[127 - 8 * k -: 8] = st[k];
        return res;
    endfunction

    assign o_fail_count = fail_count;
    assign o_pending = cipher_queue.size();

    always @(posedge i_clk) begin
        t_out_item want;
        int        errs;
        errs = 0;
        if (!i_rst_n) begin
            key_len <= KEY_128;
            for (int k = 0; k < 4; k++) key_words[k] <= '0;
            fail_count <= 0;
        end else begin
            if (psel && penable && pwrite && pready) begin
                case (paddr[5:3])
                    REG_KEY_LENGTH: key_len <= (pwdata[1:0] == KEY_SAT) ? KEY_256 : pwdata[1:0];
                    REG_KEY_WORD_0: key_words[0] <= pwdata;
                    REG_KEY_WORD_1: key_words[1] <= pwdata;
                    REG_KEY_WORD_2: key_words[2] <= pwdata;
                    REG_KEY_WORD_3: key_words[3] <= pwdata;
                    default: ;
                endcase
            end
            if (i_start && !i_busy) cipher_queue.push_back(encrypt_block(i_item));
            if (i_done) begin
                if (cipher_queue.size() == 0) begin
                    $error("unexpected result %h", i_result);
                    errs = errs + 1;
                end else begin
                    want = cipher_queue.pop_front();
                    if (want.cipher_high !== i_result.cipher_high) begin
                        $error("cipher_high: expected %h, got %h",
                               want.cipher_high, i_result.cipher_high);
                        errs = errs + 1;
                    end
                    if (want.cipher_low !== i_result.cipher_low) begin
                        $error("cipher_low: expected %h, got %h",
                               want.cipher_low, i_result.cipher_low);
                        errs = errs + 1;
                    end
                end
            end
            fail_count <= fail_count + errs;
        end
    end

endmodule

/* test/aes_block_encrypt_test.sv */
// Testbench top for the AES block encrypt: drives keys and plaintext items, gives the verdict.
`timescale 1ns / 1ps

module aes_block_encrypt_test;
    import aes_pkg::*;

    localparam int CYCLE_LIMIT = 200000;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_start = 1'b0;
    logic        o_busy;
    t_in_item    i_item = '0;
    logic        o_done;
    t_out_item   o_item;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [5:0]  paddr = '0;
    logic [63:0] pwdata = '0;
    logic [63:0] prdata;
    logic        pready;
    int          fail_count;
    int          pending;
    int          cycle_count = 0;

    always #10 i_clk = ~i_clk;

    aes_block_encrypt uut (
        .i_clk, .i_rst_n, .i_start, .o_busy, .i_item, .o_done, .o_item,
        .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
    );

    aes_block_encrypt_check checker_inst (
        .i_clk, .i_rst_n, .i_start, .i_busy(o_busy), .i_item, .i_done(o_done),
        .i_result(o_item), .psel, .penable, .pwrite, .pready, .paddr, .pwdata,
        .o_fail_count(fail_count), .o_pending(pending)
    );

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("** aes_block_encrypt: FAILED **");
            $finish;
        end
    end

    function automatic logic [63:0] rand_word();
        case ($urandom_range(0, 7))
            0: return '0;
            1: return '1;
            default: return {$urandom(), $urandom()};
        endcase
    endfunction

    task automatic write_reg(input t_reg_index idx, input logic [63:0] value);
        psel <= 1'b1;
        pwrite <= 1'b1;
        penable <= 1'b0;
        paddr <= {idx, 3'b000};
        pwdata <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic set_key(input logic [1:0] len, input logic [63:0] w0, input logic [63:0] w1,
                           input logic [63:0] w2, input logic [63:0] w3);
        write_reg(REG_KEY_LENGTH, {62'd0, len});
        write_reg(REG_KEY_WORD_0, w0);
        write_reg(REG_KEY_WORD_1, w1);
        write_reg(REG_KEY_WORD_2, w2);
        write_reg(REG_KEY_WORD_3, w3);
    endtask

    task automatic drain();
        while (pending != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
    endtask

    // hold start until accepted, then drop it unless told to keep it up
    task automatic send_block(input logic [63:0] hi, input logic [63:0] lo, input bit keep);
        i_start <= 1'b1;
        i_item <= '{plain_high: hi, plain_low: lo};
        do @(posedge i_clk); while (o_busy);
        if (!keep) begin
            i_start <= 1'b0;
            @(posedge i_clk);
        end
    endtask

    task automatic random_run(input int count);
        int burst;
        while (count > 0) begin
            burst = $urandom_range(1, 12);
            for (int k = 0; k < burst && count > 0; k++) begin
                count--;
                send_block(rand_word(), rand_word(), (k < burst - 1) && (count > 0));
            end
            if ($urandom_range(0, 2) != 0) repeat ($urandom_range(1, 20)) @(posedge i_clk);
        end
    endtask

    initial begin
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // FIPS-197 known-answer vectors with the same plaintext plus extra blocks, then corner keys
        set_key(KEY_128, 64'h0001020304050607, 64'h08090a0b0c0d0e0f, '1, '1);
        send_block(64'h0011223344556677, 64'h8899aabbccddeeff, 1'b0);
        send_block('0, '0, 1'b1);
        send_block('1, '1, 1'b0);
        drain();
        set_key(KEY_192, 64'h0001020304050607, 64'h08090a0b0c0d0e0f, 64'h1011121314151617, '1);
        send_block(64'h0011223344556677, 64'h8899aabbccddeeff, 1'b0);
        send_block('1, '0, 1'b0);
        drain();
        set_key(KEY_256, 64'h0001020304050607, 64'h08090a0b0c0d0e0f, 64'h1011121314151617,
                64'h18191a1b1c1d1e1f);
        send_block(64'h0011223344556677, 64'h8899aabbccddeeff, 1'b0);
        send_block('0, '1, 1'b0);
        drain();
        set_key(KEY_SAT, '1, '1, '1, '1);
        send_block('0, '0, 1'b0);
        send_block(64'h8000000000000001, 64'h0123456789abcdef, 1'b0);
        drain();
        set_key(KEY_128, '0, '0, '0, '0);
        send_block('0, '0, 1'b0);
        drain();

        for (int phase = 0; phase < 8; phase++) begin
            set_key(2'(phase % 4), rand_word(), rand_word(), rand_word(), rand_word());
            random_run(48);
            drain();
        end

        drain();
        if (fail_count == 0) begin
            $display("** aes_block_encrypt: PASSED **");
        end else begin
            $display("** aes_block_encrypt: FAILED **");
        end
        $finish;
    end

endmodule
